// ===== rtl/efcaf_pkg.sv =====
// Shared types, constants and a helper function for the encoder frame check
// and angle filter. No dependencies.
package efcaf_pkg;

  // Frame and result field widths
  localparam int FRAME_W     = 24;
  localparam int ANGLE_W     = 14;
  localparam int OUT_ANGLE_W = 16;
  localparam int CRC_W       = 6;
  localparam int CRC_DATA_W  = FRAME_W - CRC_W;
  localparam int FIELD_W     = 2;
  localparam int ALPHA_W     = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd26214;

  // CORDIC setup
  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 14;
  localparam int CNT_W        = $clog2(CORDIC_STEPS);
  localparam int CW           = 35;  // x/y datapath, covers both modes
  localparam int ZW           = 33;  // angle accumulator, 2^-32 turn
  localparam int CORDIC_GAIN  = 652032874;
  localparam logic [31:0] HALF_TURN = 32'h8000_0000;
  localparam int ATAN_N       = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_N);

  // Filter state, signed Q1.16
  localparam int STATE_W = 18;
  localparam int ACC_W   = 37;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] TURN_ATAN [ATAN_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

  // x^(b+6) mod x^6+x+1 for data bit b
  localparam logic [CRC_W-1:0] CRC_COL [CRC_DATA_W] = '{
    6'h03, 6'h06, 6'h0C, 6'h18, 6'h30, 6'h23, 6'h05, 6'h0A, 6'h14,
    6'h28, 6'h13, 6'h26, 6'h0F, 6'h1E, 6'h3C, 6'h3B, 6'h35, 6'h29
  };

  typedef struct packed {
    logic [ANGLE_W-1:0] raw_angle;
    logic [FIELD_W-1:0] fld_strength;
    logic               btn_pressed;
    logic               trk_loss;
    logic               crc_ok;
    logic [CRC_W-1:0]   rx_crc;
    logic [CRC_W-1:0]   computed_crc;
  } item_t;

  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_rd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ROT,
    BK_ROUND,
    BK_IIR_X,
    BK_IIR_Y,
    BK_VEC_INIT,
    BK_VEC,
    BK_OUT
  } back_state_t;

  function automatic logic [CRC_W-1:0] crc6_of(input logic [CRC_DATA_W-1:0] d);
    logic [CRC_W-1:0] crc;
    crc = '0;
    for (int b = 0; b < CRC_DATA_W; b++) begin
      if (d[b]) crc = crc ^ CRC_COL[b];
    end
    return crc;
  endfunction

endpackage

// ===== rtl/efcaf_if.sv =====
// Handshake channel interfaces: sensor frame in, result out, alpha write.
// Depends on efcaf_pkg for field widths.
interface efcaf_frame_if import efcaf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FRAME_W-1:0] frame;
  modport source (output valid, output frame, input ready);
  modport sink   (input valid, input frame, output ready);
endinterface

interface efcaf_result_if import efcaf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [OUT_ANGLE_W-1:0] filtered_angle;
  logic [ANGLE_W-1:0]     raw_angle;
  logic [FIELD_W-1:0]     fld_strength;
  logic                   btn_pressed;
  logic                   trk_loss;
  logic                   crc_ok;
  logic [CRC_W-1:0]       rx_crc;
  logic [CRC_W-1:0]       computed_crc;
  modport source (output valid, output filtered_angle, output raw_angle,
                  output fld_strength, output btn_pressed, output trk_loss,
                  output crc_ok, output rx_crc, output computed_crc,
                  input ready);
  modport sink   (input valid, input filtered_angle, input raw_angle,
                  input fld_strength, input btn_pressed, input trk_loss,
                  input crc_ok, input rx_crc, input computed_crc,
                  output ready);
endinterface

interface efcaf_cfg_if import efcaf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ALPHA_W-1:0] alpha;
  modport source (output valid, output alpha, input ready);
  modport sink   (input valid, input alpha, output ready);
endinterface

// ===== rtl/encoder_frame_check_angle_filter.sv =====
// Encoder frame check and angle filter. Takes one 24-bit sensor frame per
// transaction and returns one result per frame. Frames whose CRC6 (x^6+x+1
// over frame[23:6]) matches update an IIR-smoothed unit vector; every frame
// reports minus atan2 of that vector in 1/65536 turn plus the status fields
// and both CRC values. When the CRC matches, a frame goes through the back end
// as two 16-step CORDIC passes on one shared iteration unit plus round, the x
// and y filter updates and setup; on a mismatch only the vectoring pass and its
// setup run; a two-entry queue lets the next frames be taken while one is in work.
// Write alpha only while no frame is in flight.
// Depends on efcaf_pkg, efcaf_if, efcaf_front, efcaf_queue, efcaf_back.
module encoder_frame_check_angle_filter import efcaf_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  efcaf_frame_if.sink    in_ch,
  efcaf_result_if.source out_ch,
  efcaf_cfg_if.sink      cfg_ch
);

  logic [ALPHA_W-1:0] alpha_r;
  q_wr_t              q_wr;
  q_rd_t              q_rd;
  logic               q_full;
  logic               q_pop;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= ALPHA_RESET;
    end else if (cfg_ch.valid) begin
      alpha_r <= cfg_ch.alpha;
    end
  end

  efcaf_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_wr   (q_wr)
  );

  efcaf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_wr   (q_wr),
    .q_full (q_full),
    .q_rd   (q_rd),
    .q_pop  (q_pop)
  );

  efcaf_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .alpha  (alpha_r),
    .q_rd   (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// ===== rtl/efcaf_front.sv =====
// Front end: accepts sensor frames, splits fields and checks the CRC6.
// Depends on efcaf_pkg and efcaf_frame_if.
module efcaf_front import efcaf_pkg::*; (
  efcaf_frame_if.sink in_ch,
  input  logic        q_full,
  output q_wr_t       q_wr
);

  logic [CRC_W-1:0] calc_crc;

  assign calc_crc = crc6_of(in_ch.frame[FRAME_W-1:CRC_W]);
  assign in_ch.ready = !q_full;

  always_comb begin
    q_wr.push              = in_ch.valid && !q_full;
    q_wr.item.raw_angle    = in_ch.frame[FRAME_W-1:FRAME_W-ANGLE_W];
    q_wr.item.trk_loss     = in_ch.frame[9];
    q_wr.item.btn_pressed  = in_ch.frame[8];
    q_wr.item.fld_strength = in_ch.frame[7:6];
    q_wr.item.rx_crc       = in_ch.frame[CRC_W-1:0];
    q_wr.item.computed_crc = calc_crc;
    q_wr.item.crc_ok       = (in_ch.frame[CRC_W-1:0] == calc_crc);
  end

endmodule

// ===== rtl/efcaf_queue.sv =====
// Small register FIFO of classified frames between front and back end.
// Depends on efcaf_pkg.
module efcaf_queue import efcaf_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  q_wr_t q_wr,
  output logic  q_full,
  output q_rd_t q_rd,
  input  logic  q_pop
);

  item_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign q_full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_rd.valid = (count_r != '0);
  assign q_rd.item  = mem_r[rd_ptr_r];
  assign do_push    = q_wr.push && !q_full;
  assign do_pop     = q_pop && q_rd.valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= q_wr.item;
  end

endmodule

// ===== rtl/efcaf_back.sv =====
// Back end: rotation CORDIC, vector IIR filter, vectoring CORDIC and the
// output register. Depends on efcaf_pkg and efcaf_result_if.
module efcaf_back import efcaf_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [ALPHA_W-1:0] alpha,
  input  q_rd_t              q_rd,
  output logic               q_pop,
  efcaf_result_if.source     out_ch
);

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(CORDIC_STEPS - 1);
  localparam logic [15:0] ANGLE_KEEP = 16'(17'h0FFFF << (16 - ANGLE_BITS));

  back_state_t state_r, state_nxt;

  item_t                   item_r;
  logic signed [CW-1:0]    x_r, y_r;
  logic signed [ZW-1:0]    z_r;
  logic [1:0]              quad_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [STATE_W-1:0] cx_r, sy_r;
  logic signed [STATE_W-1:0] filt_x_r, filt_y_r;
  logic                    zero_r;
  logic                    out_valid_r;
  logic [OUT_ANGLE_W-1:0]  out_angle_r;
  item_t                   out_item_r;

  logic                    out_free, load_out;
  logic                    sub_dir;
  logic signed [CW-1:0]    x_sh, y_sh, x_step, y_step;
  logic signed [ZW-1:0]    at_ext, z_step;
  logic [15:0]             phase16;
  logic [31:0]             z32, rr;
  logic [1:0]              quad0;
  logic signed [CW-1:0]    xq, yq, vx0, vy0;
  logic signed [STATE_W-1:0] iir_s, iir_f, iir_res;
  logic [31:0]             neg_z, rnd_z;

  function automatic logic signed [STATE_W-1:0] round_q16(input logic signed [CW-1:0] v);
    logic signed [CW-1:0] t;
    t = (v + CW'(8192)) >>> 14;
    if (t < -CW'(65536)) return -STATE_W'(65536);
    if (t > CW'(65536))  return STATE_W'(65536);
    return STATE_W'(t);
  endfunction

  function automatic logic signed [STATE_W-1:0] iir(
    input logic signed [STATE_W-1:0] s,
    input logic signed [STATE_W-1:0] f,
    input logic [ALPHA_W-1:0]        a
  );
    logic [ALPHA_W:0]                  wa;
    logic signed [STATE_W+ALPHA_W:0]   p_new;
    logic signed [2*STATE_W-1:0]       p_old;
    logic signed [ACC_W-1:0]           acc;
    wa    = {1'b1, {ALPHA_W{1'b0}}} - {1'b0, a};
    p_new = s * $signed({1'b0, a});
    p_old = f * $signed({1'b0, wa});
    acc   = ACC_W'(p_new) + ACC_W'(p_old) + ACC_W'(32768);
    acc   = acc >>> 16;
    if (acc < -ACC_W'(131072)) return -STATE_W'(131072);
    if (acc > ACC_W'(131071))  return STATE_W'(131071);
    return STATE_W'(acc);
  endfunction

  // One CORDIC micro-rotation, shared by both modes
  always_comb begin
    x_sh    = x_r >>> cnt_r;
    y_sh    = y_r >>> cnt_r;
    at_ext  = ZW'(TURN_ATAN[ATAN_IDX_W'(cnt_r)]);
    sub_dir = (state_r == BK_ROT) ? !z_r[ZW-1] : y_r[CW-1];
    if (sub_dir) begin
      x_step = x_r - y_sh;
      y_step = y_r + x_sh;
      z_step = z_r - at_ext;
    end else begin
      x_step = x_r + y_sh;
      y_step = y_r - x_sh;
      z_step = z_r + at_ext;
    end
  end

  // Rotation start: fold the phase into +-1/8 turn around a quadrant axis
  always_comb begin
    phase16 = {q_rd.item.raw_angle, 2'b00} & ANGLE_KEEP;
    z32     = {phase16, 16'h0000};
    quad0   = 2'((z32 + 32'h2000_0000) >> 30);
    rr      = z32 - {quad0, 30'b0};
  end

  always_comb begin
    case (quad_r)
      2'd1:    begin xq = -y_r; yq = x_r;  end
      2'd2:    begin xq = -x_r; yq = -y_r; end
      2'd3:    begin xq = y_r;  yq = -x_r; end
      default: begin xq = x_r;  yq = y_r;  end
    endcase
  end

  assign iir_s   = (state_r == BK_IIR_Y) ? sy_r : cx_r;
  assign iir_f   = (state_r == BK_IIR_Y) ? filt_y_r : filt_x_r;
  assign iir_res = iir(iir_s, iir_f, alpha);

  assign vx0 = CW'(filt_x_r) <<< 14;
  assign vy0 = CW'(filt_y_r) <<< 14;

  assign neg_z = 32'h0 - z_r[31:0];
  assign rnd_z = neg_z + 32'h0000_8000;

  assign out_free = !out_valid_r || out_ch.ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (q_rd.valid) state_nxt = q_rd.item.crc_ok ? BK_ROT : BK_VEC_INIT;
      end
      BK_ROT: begin
        if (cnt_r == LAST_STEP) state_nxt = BK_ROUND;
      end
      BK_ROUND:    state_nxt = BK_IIR_X;
      BK_IIR_X:    state_nxt = BK_IIR_Y;
      BK_IIR_Y:    state_nxt = BK_VEC_INIT;
      BK_VEC_INIT: state_nxt = BK_VEC;
      BK_VEC: begin
        if (cnt_r == LAST_STEP) state_nxt = BK_OUT;
      end
      BK_OUT: begin
        if (out_free) state_nxt = BK_IDLE;
      end
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    q_pop    = 1'b0;
    load_out = 1'b0;
    case (state_r)
      BK_IDLE: q_pop    = q_rd.valid;
      BK_OUT:  load_out = out_free;
      default: begin
        q_pop    = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      filt_x_r    <= '0;
      filt_y_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BK_IIR_X) filt_x_r <= iir_res;
      if (state_r == BK_IIR_Y) filt_y_r <= iir_res;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BK_IDLE: begin
        item_r <= q_rd.item;
        x_r    <= CW'(CORDIC_GAIN);
        y_r    <= '0;
        z_r    <= ZW'($signed(rr));
        quad_r <= quad0;
        cnt_r  <= '0;
      end
      BK_ROT, BK_VEC: begin
        x_r   <= x_step;
        y_r   <= y_step;
        z_r   <= z_step;
        cnt_r <= cnt_r + 1'b1;
      end
      BK_ROUND: begin
        cx_r <= round_q16(xq);
        sy_r <= round_q16(yq);
      end
      BK_VEC_INIT: begin
        zero_r <= (filt_x_r == '0) && (filt_y_r == '0);
        cnt_r  <= '0;
        if (filt_x_r < 0) begin
          x_r <= -vx0;
          y_r <= -vy0;
          z_r <= ZW'(HALF_TURN);
        end else begin
          x_r <= vx0;
          y_r <= vy0;
          z_r <= '0;
        end
      end
      BK_OUT: begin
        if (load_out) begin
          out_item_r  <= item_r;
          out_angle_r <= zero_r ? '0 : rnd_z[31:16];
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_angle = out_angle_r;
  assign out_ch.raw_angle      = out_item_r.raw_angle;
  assign out_ch.fld_strength   = out_item_r.fld_strength;
  assign out_ch.btn_pressed    = out_item_r.btn_pressed;
  assign out_ch.trk_loss       = out_item_r.trk_loss;
  assign out_ch.crc_ok         = out_item_r.crc_ok;
  assign out_ch.rx_crc         = out_item_r.rx_crc;
  assign out_ch.computed_crc   = out_item_r.computed_crc;

endmodule
